FILE: rtl/wrrqp_pkg.sv
// Package for the weighted round-robin queue picker.
// Holds register indexes, field widths, defaults and the pick result type.
// No dependencies.
`default_nettype none

package wrrqp_pkg;

   localparam int DEFAULT_QUEUE_SLOTS = 4;
   localparam int DEFAULT_WEIGHT_BITS = 16;

   localparam int MASK_BITS         = 4;
   localparam int QUEUE_ID_BITS     = 2;
   localparam int QUEUE_COUNT_BITS  = 3;
   localparam int CSR_INDEX_BITS    = 3;
   localparam int CSR_DATA_BITS     = 16;
   localparam int WEIGHT_REGS       = 4;
   localparam int WEIGHT_FIELD_BITS = 16;

   localparam logic [CSR_INDEX_BITS-1:0] REG_QUEUE_COUNT  = 3'd0;
   localparam logic [CSR_INDEX_BITS-1:0] REG_INV_WEIGHT_0 = 3'd1;

   localparam logic [QUEUE_COUNT_BITS-1:0] QUEUE_COUNT_RESET = 3'd4;

   // Outcome of the served-queue search.
   typedef struct packed {
      logic                     found;
      logic [QUEUE_ID_BITS-1:0] served;
   } pick_result_type;

endpackage

`default_nettype wire

FILE: rtl/weighted_round_robin_queue_picker.sv
// Weighted round-robin queue picker, top level.
// An item taken in passes the input stage register and the result stage register
// on its way to the response port. Throughput: one item per cycle unless the
// response is stalled; the balance update feeds the next item's minimum search
// directly, so the min tree and subtract sit in one register-to-register path.
// Reset (synchronous, active high): balances zero, queue count 4, every inverse
// weight 1, both pipeline stages empty; no clearing pass is needed.
`default_nettype none

module weighted_round_robin_queue_picker #(
   parameter int QUEUE_SLOTS = wrrqp_pkg::DEFAULT_QUEUE_SLOTS,
   parameter int WEIGHT_BITS = wrrqp_pkg::DEFAULT_WEIGHT_BITS
) (
   input  logic                                 clock,
   input  logic                                 reset,
   // Request channel: one item per pop request.
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic [wrrqp_pkg::MASK_BITS-1:0]      req_nonempty_mask,
   // Response channel: one item per request.
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic [wrrqp_pkg::QUEUE_ID_BITS-1:0]  rsp_served_queue,
   output logic [wrrqp_pkg::QUEUE_ID_BITS-1:0]  rsp_scheduled_queue,
   output logic                                 rsp_all_empty,
   // Register write channel.
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [wrrqp_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [wrrqp_pkg::CSR_DATA_BITS-1:0]  csr_wdata
);
   import wrrqp_pkg::*;

   localparam int IDX_BITS = (QUEUE_SLOTS > 1) ? $clog2(QUEUE_SLOTS) : 1;

   // Configuration registers.
   logic [QUEUE_COUNT_BITS-1:0] qcount_ff, qcount_in;
   logic [WEIGHT_BITS-1:0]      weight_ff [QUEUE_SLOTS];
   logic [WEIGHT_BITS-1:0]      weight_in [QUEUE_SLOTS];

   // Scheduler state.
   logic [WEIGHT_BITS-1:0]      balance_ff [QUEUE_SLOTS];
   logic [WEIGHT_BITS-1:0]      balance_in [QUEUE_SLOTS];

   // Input stage.
   logic                        in_vld_ff, in_vld_in;
   logic [MASK_BITS-1:0]        mask_ff, mask_in;

   // Result stage.
   logic                        rsp_vld_ff, rsp_vld_in;
   logic [QUEUE_ID_BITS-1:0]    served_ff, served_in;
   logic [QUEUE_ID_BITS-1:0]    sched_ff, sched_in;
   logic                        empty_ff, empty_in;

   logic                        req_take;
   logic                        csr_take;
   logic                        advance;
   logic [QUEUE_SLOTS-1:0]      queue_act;
   logic [MASK_BITS-1:0]        act_mask;
   logic [WEIGHT_BITS-1:0]      min_value;
   logic [IDX_BITS-1:0]         min_index;
   logic [IDX_BITS+1:0]         sched_wide;
   pick_result_type             pick;

   // The input stage moves into the result stage whenever the result stage is
   // empty or its item is being taken in the same cycle.
   assign advance   = in_vld_ff && (!rsp_vld_ff || rsp_ready);
   assign req_ready = !reset && (!in_vld_ff || advance);
   assign csr_ready = !reset;
   assign req_take  = req_valid && req_ready;
   assign csr_take  = csr_valid && csr_ready;

   // Queue 0 is always active; a count of zero acts as one, and counts above
   // the number of slots simply make every slot active.
   always_comb begin
      for (int i = 0; i < QUEUE_SLOTS; i++) begin
         queue_act[i] = (i == 0) || (i < int'(qcount_ff));
      end
      for (int i = 0; i < MASK_BITS; i++) begin
         act_mask[i] = mask_ff[i] && (i < QUEUE_SLOTS) &&
                       ((i == 0) || (i < int'(qcount_ff)));
      end
   end

   wrrqp_min_tree #(
      .QUEUE_SLOTS (QUEUE_SLOTS),
      .WEIGHT_BITS (WEIGHT_BITS),
      .IDX_BITS    (IDX_BITS)
   ) u_min_tree (
      .balance   (balance_ff),
      .queue_act (queue_act),
      .min_value (min_value),
      .min_index (min_index)
   );

   wrrqp_serve_pick #(
      .IDX_BITS (IDX_BITS)
   ) u_serve_pick (
      .act_mask (act_mask),
      .sched    (min_index),
      .pick     (pick)
   );

   // Only the low two bits of the scheduled index are reported.
   assign sched_wide = (IDX_BITS + 2)'(min_index);

   always_comb begin
      // Register writes: unknown indexes and slots beyond the storage are dropped.
      qcount_in = qcount_ff;
      if (csr_take && csr_index == REG_QUEUE_COUNT) begin
         qcount_in = csr_wdata[QUEUE_COUNT_BITS-1:0];
      end
      for (int i = 0; i < QUEUE_SLOTS; i++) begin
         weight_in[i] = weight_ff[i];
         if (csr_take && i < WEIGHT_REGS &&
             csr_index == REG_INV_WEIGHT_0 + CSR_INDEX_BITS'(i)) begin
            weight_in[i] = WEIGHT_BITS'(csr_wdata[WEIGHT_FIELD_BITS-1:0]);
         end
      end

      // A pop that finds some queue nonempty charges the scheduled queue its
      // inverse weight and rebases every other active balance on the old minimum.
      for (int i = 0; i < QUEUE_SLOTS; i++) begin
         balance_in[i] = balance_ff[i];
         if (advance && pick.found && queue_act[i]) begin
            if (IDX_BITS'(i) == min_index) begin
               balance_in[i] = weight_ff[i];
            end else begin
               balance_in[i] = balance_ff[i] - min_value;
            end
         end
      end

      in_vld_in = in_vld_ff;
      mask_in   = mask_ff;
      if (req_take) begin
         in_vld_in = 1'b1;
         mask_in   = req_nonempty_mask;
      end else if (advance) begin
         in_vld_in = 1'b0;
      end

      rsp_vld_in = rsp_vld_ff;
      served_in  = served_ff;
      sched_in   = sched_ff;
      empty_in   = empty_ff;
      if (advance) begin
         rsp_vld_in = 1'b1;
         served_in  = pick.found ? pick.served : '0;
         sched_in   = sched_wide[QUEUE_ID_BITS-1:0];
         empty_in   = !pick.found;
      end else if (rsp_ready) begin
         rsp_vld_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         qcount_ff  <= QUEUE_COUNT_RESET;
         in_vld_ff  <= 1'b0;
         rsp_vld_ff <= 1'b0;
         for (int i = 0; i < QUEUE_SLOTS; i++) begin
            weight_ff[i]  <= WEIGHT_BITS'(1);
            balance_ff[i] <= '0;
         end
      end else begin
         qcount_ff  <= qcount_in;
         in_vld_ff  <= in_vld_in;
         rsp_vld_ff <= rsp_vld_in;
         for (int i = 0; i < QUEUE_SLOTS; i++) begin
            weight_ff[i]  <= weight_in[i];
            balance_ff[i] <= balance_in[i];
         end
      end
   end

   // Payload registers carry no reset.
   always_ff @(posedge clock) begin
      mask_ff   <= mask_in;
      served_ff <= served_in;
      sched_ff  <= sched_in;
      empty_ff  <= empty_in;
   end

   assign rsp_valid           = rsp_vld_ff;
   assign rsp_served_queue    = served_ff;
   assign rsp_scheduled_queue = sched_ff;
   assign rsp_all_empty       = empty_ff;

endmodule

`default_nettype wire

FILE: rtl/wrrqp_min_tree.sv
// Minimum search over the active queue balances, lowest index wins ties.
// Self-contained; sized entirely by its parameters.
`default_nettype none

module wrrqp_min_tree #(
   parameter int QUEUE_SLOTS = 4,
   parameter int WEIGHT_BITS = 16,
   parameter int IDX_BITS    = 2
) (
   input  logic [WEIGHT_BITS-1:0] balance [QUEUE_SLOTS],
   input  logic [QUEUE_SLOTS-1:0] queue_act,
   output logic [WEIGHT_BITS-1:0] min_value,
   output logic [IDX_BITS-1:0]    min_index
);

   localparam int LEVELS = (QUEUE_SLOTS > 1) ? $clog2(QUEUE_SLOTS) : 0;
   localparam int PAD    = 1 << LEVELS;

   logic [WEIGHT_BITS-1:0] node_val [LEVELS+1][PAD];
   logic [IDX_BITS-1:0]    node_idx [LEVELS+1][PAD];
   logic                   node_vld [LEVELS+1][PAD];

   // Active queues form a prefix and queue 0 is always active, so taking the
   // left node on a tie keeps the lowest index.
   always_comb begin
      for (int l = 0; l <= LEVELS; l++) begin
         for (int j = 0; j < PAD; j++) begin
            node_val[l][j] = '0;
            node_idx[l][j] = '0;
            node_vld[l][j] = 1'b0;
         end
      end
      for (int j = 0; j < QUEUE_SLOTS; j++) begin
         node_val[0][j] = balance[j];
         node_idx[0][j] = IDX_BITS'(j);
         node_vld[0][j] = queue_act[j];
      end
      for (int l = 1; l <= LEVELS; l++) begin
         for (int j = 0; j < (PAD >> l); j++) begin
            if (node_vld[l-1][2*j] &&
                (!node_vld[l-1][2*j+1] ||
                 node_val[l-1][2*j] <= node_val[l-1][2*j+1])) begin
               node_val[l][j] = node_val[l-1][2*j];
               node_idx[l][j] = node_idx[l-1][2*j];
               node_vld[l][j] = 1'b1;
            end else begin
               node_val[l][j] = node_val[l-1][2*j+1];
               node_idx[l][j] = node_idx[l-1][2*j+1];
               node_vld[l][j] = node_vld[l-1][2*j+1];
            end
         end
      end
   end

   assign min_value = node_val[LEVELS][0];
   assign min_index = node_idx[LEVELS][0];

endmodule

`default_nettype wire

FILE: rtl/wrrqp_serve_pick.sv
// Served-queue search: first nonempty active queue at or above the scheduled
// one, else the nearest below. Depends on wrrqp_pkg.
`default_nettype none

module wrrqp_serve_pick #(
   parameter int IDX_BITS = 2
) (
   input  logic [wrrqp_pkg::MASK_BITS-1:0] act_mask,
   input  logic [IDX_BITS-1:0]             sched,
   output wrrqp_pkg::pick_result_type      pick
);
   import wrrqp_pkg::*;

   logic [MASK_BITS-1:0]     above;
   logic [QUEUE_ID_BITS-1:0] served_up;
   logic [QUEUE_ID_BITS-1:0] served_dn;

   always_comb begin
      served_up = '0;
      served_dn = '0;
      for (int i = 0; i < MASK_BITS; i++) begin
         above[i] = act_mask[i] && (int'(sched) <= i);
      end
      for (int i = MASK_BITS - 1; i >= 0; i--) begin
         if (above[i]) begin
            served_up = QUEUE_ID_BITS'(i);
         end
      end
      // With nothing at or above, every set bit lies below: take the highest.
      for (int i = 0; i < MASK_BITS; i++) begin
         if (act_mask[i]) begin
            served_dn = QUEUE_ID_BITS'(i);
         end
      end
      pick.found  = |act_mask;
      pick.served = (|above) ? served_up : served_dn;
   end

endmodule

`default_nettype wire

FILE: rtl/wrrqp_checker.sv
// Port-level checks for the weighted round-robin queue picker, with the bind.
// Depends on wrrqp_pkg and on the top level's port list.
`default_nettype none

module wrrqp_checker (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   input  logic                                 req_ready,
   input  logic [wrrqp_pkg::MASK_BITS-1:0]      req_nonempty_mask,
   input  logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   input  logic [wrrqp_pkg::QUEUE_ID_BITS-1:0]  rsp_served_queue,
   input  logic [wrrqp_pkg::QUEUE_ID_BITS-1:0]  rsp_scheduled_queue,
   input  logic                                 rsp_all_empty,
   input  logic                                 csr_valid,
   input  logic                                 csr_ready,
   input  logic [wrrqp_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [wrrqp_pkg::CSR_DATA_BITS-1:0]  csr_wdata
);
   import wrrqp_pkg::*;

   // Nothing comes out in the cycle after a reset.
   a_empty_after_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid right after reset");

   // A new response only appears after an item was taken in and passed the input stage.
   a_rsp_has_req: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_valid && req_ready, 2))
      else $error("response without a matching request");

   // A response with no active nonempty queue always reports queue zero as served.
   a_empty_serves_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_all_empty |-> rsp_served_queue == '0)
      else $error("all_empty response with nonzero served queue");

   // A stalled response holds its fields.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_served_queue) &&
      $stable(rsp_scheduled_queue) && $stable(rsp_all_empty))
      else $error("stalled response changed");

endmodule

bind weighted_round_robin_queue_picker wrrqp_checker u_wrrqp_checker (.*);

`default_nettype wire
